[rtl/assert_macros.svh]
// assertion macros for the per-site latency statistics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CHK_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHK_IMP(lbl, ck, rn, ante, cons)
`define CHK_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

[rtl/pslws_pkg.sv]
// types and constants for the per-site latency statistics block
package pslws_pkg;

  localparam int NUM_SITES = 16;
  localparam int FRAC_BITS = 16;
  localparam int SITE_W    = 4;
  localparam int LAT_W     = 16;
  localparam int TIME_W    = 48;
  localparam int MEAN_W    = 32;
  localparam int CNT_W     = 32;
  localparam int M2_W      = 64;
  localparam int XW        = LAT_W + FRAC_BITS;
  localparam int DW        = (XW > MEAN_W) ? XW : MEAN_W;
  localparam int SW        = M2_W / 2;
  localparam int AW        = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
  localparam int CW        = $clog2(M2_W);
  localparam int PW        = 2 * M2_W;

  typedef struct packed {
    logic [SITE_W-1:0] site_index;
    logic [LAT_W-1:0]  latency_ms;
    logic [TIME_W-1:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic [SITE_W-1:0] site_out;
    logic [MEAN_W-1:0] mean_latency;
    logic [MEAN_W-1:0] std_deviation;
    logic [CNT_W-1:0]  sample_count;
    logic [TIME_W-1:0] first_time;
    logic [TIME_W-1:0] last_time;
  } out_req_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [M2_W-1:0]   m2;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] first_time;
    logic [TIME_W-1:0] last_time;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DIV1,
    S_UPD,
    S_MUL,
    S_ACC,
    S_DIV2,
    S_SQ0,
    S_SQRT,
    S_OUT
  } state_t;

endpackage

[rtl/per_site_latency_welford_stats_top.sv]
// per-site latency statistics: welford mean, m2, count, times and std deviation
// sequence: the shift-subtract divider (32 steps for the mean, 64 for m2 over
//   count - 1) and the 32-step square root produce the result; the m2 division
//   and the square root are skipped when the count is below two, and the square
//   root alone when the deviation saturates
// requests: next request taken the cycle after the result loads, none before it;
//   a failed query is taken in idle and gives no result
// reset: all site entries read as zero after reset (per-entry valid bits)
`include "assert_macros.svh"
module per_site_latency_welford_stats_top import pslws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  state_t state_r, state_nxt;

  logic [SITE_W-1:0] site_r;
  logic [DW-1:0]     x_r;
  logic [TIME_W-1:0] now_r;
  entry_t            ent_r;
  logic [CNT_W-1:0]  n_r;
  logic              up_r;
  logic [DW-1:0]     d1_r;
  logic [MEAN_W-1:0] newmean_r;
  logic [DW-1:0]     d2_r;
  logic [2*DW-1:0]   prod_r;
  logic [M2_W-1:0]   dq_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [CW-1:0]     cnt_r;
  logic [M2_W-1:0]   rad_r;
  logic [SW+1:0]     srem_r;
  logic [SW-1:0]     root_r;
  logic [SW-1:0]     sd_r;

  entry_t             mem [NUM_SITES];
  entry_t             rd_r;
  logic               rd_vld_r;
  logic [NUM_SITES-1:0] vld_r;

  logic     out_valid_r;
  out_req_t out_data_r;

  logic go, mem_re, mem_we, out_load;

  // read stage
  entry_t            cur_ent;
  logic [CNT_W-1:0]  n_inc;
  logic [DW-1:0]     mean_x;
  logic              up_c;
  logic [DW-1:0]     d1_c;
  // divider step
  logic [CNT_W:0]    rem_s;
  logic              div_ge;
  logic [CNT_W-1:0]  rem_nx;
  // mean update
  logic [DW:0]       nm_wide;
  logic [MEAN_W-1:0] nm;
  logic [DW-1:0]     nm_x;
  logic [DW-1:0]     q1;
  logic [DW-1:0]     d2_c;
  // m2 update
  logic [PW-1:0]     prod_ext;
  logic [M2_W-1:0]   inc;
  logic [M2_W:0]     m2_sum;
  logic [M2_W-1:0]   m2_new;
  entry_t            wr_ent;
  // sqrt step
  logic [SW+3:0]     srem_s;
  logic [SW+3:0]     trial;
  logic              sq_ge;
  logic [SW+3:0]     srem_d;

  assign go = in_valid && !in_stall && (in_data.latency_ms != '0) &&
              (32'(in_data.site_index) < NUM_SITES);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (go) state_nxt = S_READ;
      S_READ: state_nxt = S_DIV1;
      S_DIV1: if (cnt_r == '0) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = (n_r < CNT_W'(2)) ? S_OUT : S_DIV2;
      S_DIV2: if (cnt_r == '0) state_nxt = S_SQ0;
      S_SQ0:  state_nxt = (|dq_r[M2_W-1:M2_W-FRAC_BITS]) ? S_OUT : S_SQRT;
      S_SQRT: if (cnt_r == '0) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = (state_r != S_IDLE);
    mem_re   = go;
    mem_we   = (state_r == S_ACC);
    out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    cur_ent = rd_vld_r ? rd_r : '0;
    n_inc   = (&cur_ent.count) ? cur_ent.count : cur_ent.count + 1'b1;
    mean_x  = DW'(cur_ent.mean);
    up_c    = (x_r >= mean_x);
    d1_c    = up_c ? x_r - mean_x : mean_x - x_r;

    rem_s  = {rem_r, dq_r[M2_W-1]};
    div_ge = (rem_s >= {1'b0, div_r});
    rem_nx = div_ge ? CNT_W'(rem_s - {1'b0, div_r}) : CNT_W'(rem_s);

    q1      = dq_r[DW-1:0];
    nm_wide = up_r ? {1'b0, DW'(ent_r.mean)} + {1'b0, q1}
                   : {1'b0, DW'(ent_r.mean)} - {1'b0, q1};
    nm      = (nm_wide > (DW+1)'({MEAN_W{1'b1}})) ? '1 : nm_wide[MEAN_W-1:0];
    nm_x    = DW'(nm);
    if (up_r) d2_c = (x_r >= nm_x) ? x_r - nm_x : '0;
    else      d2_c = (nm_x >= x_r) ? nm_x - x_r : '0;

    prod_ext = PW'(prod_r);
    inc      = (|prod_ext[PW-1:M2_W+FRAC_BITS]) ? '1
                                                : prod_ext[M2_W+FRAC_BITS-1:FRAC_BITS];
    m2_sum   = {1'b0, ent_r.m2} + {1'b0, inc};
    m2_new   = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];

    wr_ent.mean  = newmean_r;
    wr_ent.m2    = m2_new;
    wr_ent.count = n_r;
    if (n_r == CNT_W'(1)) begin
      wr_ent.first_time = now_r;
      wr_ent.last_time  = now_r;
    end else begin
      wr_ent.first_time = ent_r.first_time;
      wr_ent.last_time  = (now_r > ent_r.last_time) ? now_r : ent_r.last_time;
    end

    srem_s = {srem_r, rad_r[M2_W-1:M2_W-2]};
    trial  = {2'b00, root_r, 2'b01};
    sq_ge  = (srem_s >= trial);
    srem_d = sq_ge ? srem_s - trial : srem_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (mem_we) vld_r[AW'(site_r)] <= 1'b1;
      if (mem_re) rd_vld_r <= vld_r[AW'(in_data.site_index)];
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(site_r)] <= wr_ent;
    if (mem_re) rd_r <= mem[AW'(in_data.site_index)];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          site_r <= in_data.site_index;
          x_r    <= DW'(in_data.latency_ms) << FRAC_BITS;
          now_r  <= in_data.now_ms;
        end
      end
      S_READ: begin
        ent_r <= cur_ent;
        n_r   <= n_inc;
        up_r  <= up_c;
        d1_r  <= d1_c;
        dq_r  <= {d1_c, (M2_W-DW)'(0)};
        rem_r <= '0;
        div_r <= n_inc;
        cnt_r <= CW'(DW-1);
      end
      S_DIV1, S_DIV2: begin
        rem_r <= rem_nx;
        dq_r  <= {dq_r[M2_W-2:0], div_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      S_UPD: begin
        newmean_r <= nm;
        d2_r      <= d2_c;
      end
      S_MUL: begin
        prod_r <= d1_r * d2_r;
      end
      S_ACC: begin
        ent_r <= wr_ent;
        dq_r  <= m2_new;
        rem_r <= '0;
        div_r <= n_r - 1'b1;
        cnt_r <= CW'(M2_W-1);
        sd_r  <= '0;
      end
      S_SQ0: begin
        sd_r   <= '1;
        rad_r  <= {dq_r[M2_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= CW'(SW-1);
      end
      S_SQRT: begin
        srem_r <= srem_d[SW+1:0];
        root_r <= {root_r[SW-2:0], sq_ge};
        rad_r  <= {rad_r[M2_W-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) sd_r <= {root_r[SW-2:0], sq_ge};
      end
      S_OUT: begin
        if (out_load) begin
          out_data_r.site_out      <= site_r;
          out_data_r.mean_latency  <= newmean_r;
          out_data_r.std_deviation <= MEAN_W'(sd_r);
          out_data_r.sample_count  <= n_r;
          out_data_r.first_time    <= ent_r.first_time;
          out_data_r.last_time     <= ent_r.last_time;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CHK_NXT(a_go_reads, clk, rst_n, go, state_r == S_READ)
  `CHK_IMP(a_we_in_acc, clk, rst_n, mem_we, state_r == S_ACC)
  `CHK_IMP(a_div2_nonzero, clk, rst_n, state_r == S_DIV2, div_r != '0)
  `CHK_NXT(a_out_loads, clk, rst_n, out_load, out_valid_r)
  `CHK_IMP(a_acc_count, clk, rst_n, state_r == S_ACC, n_r != '0)

endmodule

[tb/per_site_latency_welford_stats_checker.sv]
// checker: predicts per-site welford statistics and compares results in order
module per_site_latency_welford_stats_checker import pslws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_req_t out_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [MEAN_W-1:0] site_mean [NUM_SITES];
  logic [M2_W-1:0]   site_m2 [NUM_SITES];
  logic [CNT_W-1:0]  site_count [NUM_SITES];
  logic [TIME_W-1:0] site_first [NUM_SITES];
  logic [TIME_W-1:0] site_last [NUM_SITES];
  out_req_t          stats_due [$];

  initial begin
    fail_count = 0;
    pending = 0;
    for (int i = 0; i < NUM_SITES; i++) begin
      site_mean[i] = '0;
      site_m2[i] = '0;
      site_count[i] = '0;
      site_first[i] = '0;
      site_last[i] = '0;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fail_count++;
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  function automatic logic [31:0] fixed_root(input logic [63:0] q);
    logic [79:0] v;
    logic [31:0] r;
    logic [31:0] t;
    v = {q, 16'b0};
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if ({16'b0, 64'(t) * 64'(t)} <= v) r = t;
    end
    return r;
  endfunction

  task automatic welford_update(input in_req_t req);
    logic [3:0]   s;
    logic [31:0]  x, mean, n, d1, d2, newmean;
    logic [32:0]  wide_mean;
    logic [127:0] prod;
    logic [63:0]  inc;
    logic [64:0]  sum;
    logic         up;
    out_req_t     res;
    s = req.site_index;
    if (req.latency_ms == 0) return;
    x = {req.latency_ms, 16'b0};
    mean = site_mean[s];
    n = (site_count[s] != '1) ? site_count[s] + 1 : site_count[s];
    up = x >= mean;
    d1 = up ? x - mean : mean - x;
    wide_mean = up ? 33'(mean) + 33'(d1 / n) : 33'(mean) - 33'(d1 / n);
    newmean = wide_mean[32] ? '1 : wide_mean[31:0];
    if (up) d2 = (x >= newmean) ? x - newmean : '0;
    else d2 = (newmean >= x) ? newmean - x : '0;
    prod = 128'(d1) * 128'(d2);
    inc = (prod[127:80] != 0) ? '1 : prod[79:16];
    sum = 65'(site_m2[s]) + 65'(inc);
    site_m2[s] = sum[64] ? '1 : sum[63:0];
    site_mean[s] = newmean;
    site_count[s] = n;
    if (n == 1) begin
      site_first[s] = req.now_ms;
      site_last[s] = req.now_ms;
    end else if (req.now_ms > site_last[s]) begin
      site_last[s] = req.now_ms;
    end
    res.site_out = s;
    res.mean_latency = newmean;
    res.std_deviation = (n < 2) ? '0 : fixed_root(site_m2[s] / 64'(n - 1));
    res.sample_count = n;
    res.first_time = site_first[s];
    res.last_time = site_last[s];
    stats_due.push_back(res);
  endtask

  always @(posedge clk) begin
    out_req_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) welford_update(in_data);
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          report("unexpected result site", 64'(out_data.site_out), 64'(0));
        end else begin
          want = stats_due.pop_front();
          if (out_data.site_out !== want.site_out)
            report("site_out", 64'(out_data.site_out), 64'(want.site_out));
          if (out_data.mean_latency !== want.mean_latency)
            report("mean_latency", 64'(out_data.mean_latency), 64'(want.mean_latency));
          if (out_data.std_deviation !== want.std_deviation)
            report("std_deviation", 64'(out_data.std_deviation), 64'(want.std_deviation));
          if (out_data.sample_count !== want.sample_count)
            report("sample_count", 64'(out_data.sample_count), 64'(want.sample_count));
          if (out_data.first_time !== want.first_time)
            report("first_time", 64'(out_data.first_time), 64'(want.first_time));
          if (out_data.last_time !== want.last_time)
            report("last_time", 64'(out_data.last_time), 64'(want.last_time));
        end
      end
    end
    pending <= stats_due.size();
  end
endmodule

[tb/per_site_latency_welford_stats_top_test.sv]
// testbench top: drives latency samples, stalls results and gives the verdict
module per_site_latency_welford_stats_top_test;
  import pslws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;
  int       fail_count;
  int       pending;
  int       hold_cycles = 0;
  int       cycle_count = 0;
  logic [47:0] clock_ms = 48'd1000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  per_site_latency_welford_stats_top u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  per_site_latency_welford_stats_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // result stall pattern with one long hold
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (cycle_count % 2000 < 700) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  function automatic in_req_t make_sample();
    in_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.site_index = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom);
    if (pick < 8) r.latency_ms = '0;
    else if (pick < 30) r.latency_ms = 16'($urandom);
    else if (pick < 60) r.latency_ms = 16'(200 + 40 * r.site_index + $urandom_range(0, 30));
    else r.latency_ms = 16'($urandom_range(1, 50));
    pick = $urandom_range(0, 99);
    if (pick < 10) r.now_ms = {16'($urandom), 32'($urandom)};
    else if (pick < 20) r.now_ms = clock_ms - 48'($urandom_range(0, 500));
    else r.now_ms = clock_ms;
    return r;
  endfunction

  task automatic send(input in_req_t r, input bit last);
    int gap;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clock_ms = clock_ms + 48'($urandom_range(1, 1000));
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
    if (last || gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    in_req_t d;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send('{site_index: 4'd0, latency_ms: 16'd1, now_ms: 48'd0}, 1'b0);
    send('{site_index: 4'd0, latency_ms: 16'hffff, now_ms: '1}, 1'b0);
    send('{site_index: 4'd0, latency_ms: 16'hffff, now_ms: 48'd5}, 1'b0);
    send('{site_index: 4'd0, latency_ms: 16'd0, now_ms: 48'd7}, 1'b0);
    send('{site_index: 4'd15, latency_ms: 16'd0, now_ms: 48'd9}, 1'b0);
    send('{site_index: 4'd15, latency_ms: 16'h8000, now_ms: 48'h555555555555}, 1'b0);
    send('{site_index: 4'd1, latency_ms: 16'hffff, now_ms: 48'd100}, 1'b0);
    send('{site_index: 4'd1, latency_ms: 16'hffff, now_ms: 48'd100}, 1'b0);
    send('{site_index: 4'd1, latency_ms: 16'd1, now_ms: 48'd101}, 1'b0);
    send('{site_index: 4'd1, latency_ms: 16'd1, now_ms: 48'haaaaaaaaaaaa}, 1'b0);
    for (int s = 2; s < 15; s++) begin
      d.site_index = 4'(s);
      d.latency_ms = 16'($urandom_range(1, 65535));
      d.now_ms = clock_ms;
      send(d, 1'b0);
    end

    for (int i = 0; i < 1000; i++) begin
      if (i == 300) hold_cycles = 1500;
      if (i == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      send(make_sample(), i == 999);
    end

    @(posedge clk);
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
